/* rtl/core/htd_pkg.sv */
`timescale 1ns / 1ps
// ============================================================================
// htd_pkg
// Shared types and constants for the Huffman tree load and decode block:
// item structs, node layout, status codes and the control structs that pass
// between the table builder, the tree walker and the top level.
// ============================================================================
package htd_pkg;

    // Node index field width inside a stored node
    localparam int IdxW     = 9;
    // Bits in one symbol of the coding table
    localparam int SymBits  = 8;
    localparam int CountW   = 32;

    // Input bit kinds
    localparam logic FUNC_TABLE = 1'b0;
    localparam logic FUNC_DATA  = 1'b1;

    typedef enum logic [1:0] {
        ST_SYMBOL       = 2'd0,
        ST_BAD_TABLE    = 2'd1,
        ST_OUT_OF_PHASE = 2'd2,
        ST_OVERFLOW     = 2'd3
    } t_status;

    typedef struct packed {
        logic func;
        logic bit_value;
    } t_in_item;

    typedef struct packed {
        logic [SymBits-1:0] symbol;
        logic               last;
        t_status            status;
    } t_out_item;

    // Tree node: a leaf keeps its symbol in the right field
    typedef struct packed {
        logic            leaf;
        logic [IdxW-1:0] left;
        logic [IdxW-1:0] right;
    } t_node;

    typedef struct packed {
        logic            en;
        logic [IdxW-1:0] addr;
        t_node           data;
    } t_node_wr;

    // Outcome of one table bit
    typedef struct packed {
        logic    err;
        t_status status;
        logic    tree_end;
    } t_build_res;

    // Outcome of one data bit
    typedef struct packed {
        logic               emit;
        logic [SymBits-1:0] symbol;
        logic               last;
        logic               done;
    } t_walk_res;

endpackage

/* rtl/core/htd_builder.sv */
`timescale 1ns / 1ps
// ============================================================================
// htd_builder
// Rebuilds the tree from the post-order table code. Holds the build stack in
// a synchronous memory, keeps the top entry and its node in registers, and
// issues node writes toward the tree walker's node memory.
// ============================================================================
module htd_builder #(
    parameter int MAX_NODES   = 512,
    parameter int STACK_DEPTH = 256
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_rd_en,
    input  logic                i_step,
    input  logic                i_bit,
    output htd_pkg::t_build_res o_res,
    output htd_pkg::t_node_wr   o_node_wr,
    output htd_pkg::t_node      o_top_node
);

    localparam int NAW = $clog2(MAX_NODES);
    localparam int NCW = $clog2(MAX_NODES + 1);
    localparam int SAW = $clog2(STACK_DEPTH);
    localparam int FW  = $clog2(STACK_DEPTH + 1);

    logic [NAW-1:0]             r_stack [STACK_DEPTH];
    logic [NAW-1:0]             r_stack_rd;

    logic [FW-1:0]              r_fill, n_fill;
    logic [NCW-1:0]             r_nodes, n_nodes;
    logic [htd_pkg::SymBits-1:0] r_shift, n_shift;
    logic [3:0]                 r_bits_left, n_bits_left;
    logic [NAW-1:0]             r_top, n_top;
    htd_pkg::t_node             r_top_node, n_top_node;

    logic [FW-1:0]              fill_m2;
    logic [htd_pkg::SymBits-1:0] sym_next;
    logic                       nodes_full;
    logic                       stack_full;
    logic                       node_we;
    htd_pkg::t_node             node_data;
    logic                       stk_we;
    logic [SAW-1:0]             stk_waddr;

    assign fill_m2    = r_fill - FW'(2);
    assign sym_next   = {r_shift[htd_pkg::SymBits-2:0], i_bit};
    assign nodes_full = (r_nodes >= NCW'(MAX_NODES));
    assign stack_full = (r_fill >= FW'(STACK_DEPTH));

    // Stack memory: read the entry below the top on accept, write on commit
    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_stack_rd <= r_stack[fill_m2[SAW-1:0]];
        end
        if (i_step && stk_we) begin
            r_stack[stk_waddr] <= r_nodes[NAW-1:0];
        end
    end

    // Decode one table bit
    always_comb begin
        n_fill      = r_fill;
        n_nodes     = r_nodes;
        n_shift     = r_shift;
        n_bits_left = r_bits_left;
        n_top       = r_top;
        n_top_node  = r_top_node;
        o_res       = '{err: 1'b0, status: htd_pkg::ST_SYMBOL, tree_end: 1'b0};
        node_we     = 1'b0;
        node_data   = '0;
        stk_we      = 1'b0;
        stk_waddr   = r_fill[SAW-1:0];
        if (r_bits_left != 4'd0) begin
            n_shift     = sym_next;
            n_bits_left = r_bits_left - 4'd1;
            if (r_bits_left == 4'd1) begin
                if (nodes_full || stack_full) begin
                    o_res.err    = 1'b1;
                    o_res.status = htd_pkg::ST_OVERFLOW;
                end else begin
                    // push a leaf
                    node_data  = '{leaf: 1'b1, left: '0,
                                   right: htd_pkg::IdxW'(sym_next)};
                    node_we    = 1'b1;
                    stk_we     = 1'b1;
                    n_fill     = r_fill + FW'(1);
                    n_top      = r_nodes[NAW-1:0];
                    n_top_node = node_data;
                    n_nodes    = r_nodes + NCW'(1);
                end
            end
        end else if (i_bit) begin
            n_bits_left = 4'(htd_pkg::SymBits);
            n_shift     = '0;
        end else if (r_fill == FW'(1)) begin
            o_res.tree_end = 1'b1;
            n_fill         = '0;
        end else if (r_fill == '0) begin
            o_res.err    = 1'b1;
            o_res.status = htd_pkg::ST_BAD_TABLE;
        end else if (nodes_full) begin
            o_res.err    = 1'b1;
            o_res.status = htd_pkg::ST_OVERFLOW;
        end else begin
            // join the top two entries
            node_data  = '{leaf: 1'b0, left: htd_pkg::IdxW'(r_stack_rd),
                           right: htd_pkg::IdxW'(r_top)};
            node_we    = 1'b1;
            stk_we     = 1'b1;
            stk_waddr  = fill_m2[SAW-1:0];
            n_fill     = r_fill - FW'(1);
            n_top      = r_nodes[NAW-1:0];
            n_top_node = node_data;
            n_nodes    = r_nodes + NCW'(1);
        end
    end

    assign o_node_wr.en   = i_step && node_we;
    assign o_node_wr.addr = htd_pkg::IdxW'(r_nodes[NAW-1:0]);
    assign o_node_wr.data = node_data;
    assign o_top_node     = r_top_node;

    // Build state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fill      <= '0;
            r_nodes     <= '0;
            r_shift     <= '0;
            r_bits_left <= '0;
        end else if (i_step) begin
            r_fill      <= n_fill;
            r_nodes     <= n_nodes;
            r_shift     <= n_shift;
            r_bits_left <= n_bits_left;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_step) begin
            r_top      <= n_top;
            r_top_node <= n_top_node;
        end
    end

    a_fill_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_fill <= FW'(STACK_DEPTH) && r_nodes <= NCW'(MAX_NODES))
        else $error("build stack or node count past capacity");

    a_no_write_on_err: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_node_wr.en |-> !o_res.err && !o_res.tree_end)
        else $error("node write on error or table end");

endmodule

/* rtl/core/htd_walker.sv */
`timescale 1ns / 1ps
// ============================================================================
// htd_walker
// Holds the node memory and walks the tree one data bit at a time. The node
// of the current position and the root node live in registers; the child
// picked by the bit is read from memory into a register and resolved from it.
// ============================================================================
module htd_walker #(
    parameter int MAX_NODES = 512
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_rd_en,
    input  logic                        i_rd_bit,
    input  logic                        i_step,
    input  htd_pkg::t_node_wr           i_node_wr,
    input  logic                        i_root_load,
    input  htd_pkg::t_node              i_root_node,
    input  logic [htd_pkg::CountW-1:0]  i_out_count,
    output htd_pkg::t_walk_res          o_res
);

    localparam int NAW = $clog2(MAX_NODES);

    htd_pkg::t_node               r_mem [MAX_NODES];
    htd_pkg::t_node               r_rd_node;
    htd_pkg::t_node               r_walk_node;
    htd_pkg::t_node               r_root_node;
    logic [htd_pkg::CountW-1:0]   r_emitted;

    logic [NAW-1:0]               rd_addr;
    htd_pkg::t_node               hit_node;
    logic [htd_pkg::CountW-1:0]   emitted_inc;

    assign rd_addr = NAW'(i_rd_bit ? r_walk_node.right : r_walk_node.left);

    // Node memory: fill from the builder, read the chosen child on accept
    always_ff @(posedge i_clk) begin
        if (i_node_wr.en) begin
            r_mem[NAW'(i_node_wr.addr)] <= i_node_wr.data;
        end
        if (i_rd_en) begin
            r_rd_node <= r_mem[rd_addr];
        end
    end

    // A one-leaf tree emits the root on every bit
    assign hit_node    = r_root_node.leaf ? r_root_node : r_rd_node;
    assign emitted_inc = r_emitted + htd_pkg::CountW'(1);

    assign o_res.emit   = hit_node.leaf;
    assign o_res.symbol = hit_node.right[htd_pkg::SymBits-1:0];
    assign o_res.last   = (emitted_inc == i_out_count);
    assign o_res.done   = (r_emitted >= i_out_count);

    // Advance the walk position; return to the root after a leaf
    always_ff @(posedge i_clk) begin
        if (i_root_load) begin
            r_root_node <= i_root_node;
            r_walk_node <= i_root_node;
        end else if (i_step) begin
            r_walk_node <= hit_node.leaf ? r_root_node : r_rd_node;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_emitted <= '0;
        end else if (i_step && hit_node.leaf) begin
            r_emitted <= emitted_inc;
        end
    end

    a_step_not_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_step |-> !o_res.done && !i_root_load)
        else $error("walk step after done or during root load");

endmodule

/* rtl/core/huffman_tree_load_and_decode_top.sv */
`timescale 1ns / 1ps
// ============================================================================
// huffman_tree_load_and_decode_top
// An accepted item is held in the item stage until it commits; no new item
// is taken meanwhile. Each bit reads the node memory (data) or the stack
// memory (table join) and resolves from the registered read data.
// A result waiting on o_out_valid does not block the next item's read cycle.
// Reset (synchronous, active low) clears the build and emitted counts, the
// output_count register and the halt flag; memories are not cleared.
// ============================================================================
module huffman_tree_load_and_decode_top #(
    parameter int MAX_NODES   = 512,
    parameter int STACK_DEPTH = 256
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_in_valid,
    output logic                        o_in_stall,
    input  htd_pkg::t_in_item           i_in_item,
    output logic                        o_out_valid,
    input  logic                        i_out_stall,
    output htd_pkg::t_out_item          o_out_item,
    input  logic                        i_cfg_we,
    input  logic [htd_pkg::CountW-1:0]  i_cfg_wdata
);

    logic                         r_s2_valid;
    htd_pkg::t_in_item            r_s2_item;
    logic                         r_halted;
    logic                         r_tree_ready;
    logic [htd_pkg::CountW-1:0]   r_out_count;
    logic                         r_out_valid, n_out_valid;
    htd_pkg::t_out_item           r_out_item;

    logic                         accept;
    logic                         s2_has_res;
    htd_pkg::t_out_item           s2_res;
    logic                         build_sel;
    logic                         walk_sel;
    logic                         s2_complete;
    logic                         build_step;
    logic                         walk_step;
    logic                         root_load;

    htd_pkg::t_build_res          build_res;
    htd_pkg::t_node_wr            node_wr;
    htd_pkg::t_node               top_node;
    htd_pkg::t_walk_res           walk_res;

    // Hold new items while one is in flight, until it commits
    assign o_in_stall = r_s2_valid;
    assign accept     = i_in_valid && !o_in_stall;

    htd_builder #(
        .MAX_NODES   (MAX_NODES),
        .STACK_DEPTH (STACK_DEPTH)
    ) u_builder (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_rd_en    (accept),
        .i_step     (build_step),
        .i_bit      (r_s2_item.bit_value),
        .o_res      (build_res),
        .o_node_wr  (node_wr),
        .o_top_node (top_node)
    );

    htd_walker #(
        .MAX_NODES (MAX_NODES)
    ) u_walker (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_rd_en     (accept),
        .i_rd_bit    (i_in_item.bit_value),
        .i_step      (walk_step),
        .i_node_wr   (node_wr),
        .i_root_load (root_load),
        .i_root_node (top_node),
        .i_out_count (r_out_count),
        .o_res       (walk_res)
    );

    // Resolve the item in flight into a result or none
    always_comb begin
        s2_has_res = 1'b0;
        s2_res     = '{symbol: '0, last: 1'b0, status: htd_pkg::ST_SYMBOL};
        build_sel  = 1'b0;
        walk_sel   = 1'b0;
        if (r_halted) begin
            s2_has_res    = 1'b1;
            s2_res.status = htd_pkg::ST_OUT_OF_PHASE;
        end else if (r_s2_item.func == htd_pkg::FUNC_TABLE) begin
            if (r_tree_ready) begin
                s2_has_res    = 1'b1;
                s2_res.status = htd_pkg::ST_OUT_OF_PHASE;
            end else begin
                build_sel = 1'b1;
                if (build_res.err) begin
                    s2_has_res    = 1'b1;
                    s2_res.status = build_res.status;
                end
            end
        end else begin
            if (!r_tree_ready || walk_res.done) begin
                s2_has_res    = 1'b1;
                s2_res.status = htd_pkg::ST_OUT_OF_PHASE;
            end else begin
                walk_sel = 1'b1;
                if (walk_res.emit) begin
                    s2_has_res    = 1'b1;
                    s2_res.symbol = walk_res.symbol;
                    s2_res.last   = walk_res.last;
                end
            end
        end
    end

    // Commit unless the result has nowhere to go
    assign s2_complete = r_s2_valid && (!s2_has_res || !r_out_valid || !i_out_stall);
    assign build_step  = s2_complete && build_sel;
    assign walk_step   = s2_complete && walk_sel;
    assign root_load   = build_step && build_res.tree_end;
    assign n_out_valid = (r_out_valid && i_out_stall) || (s2_complete && s2_has_res);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s2_valid   <= 1'b0;
            r_halted     <= 1'b0;
            r_tree_ready <= 1'b0;
            r_out_count  <= '0;
            r_out_valid  <= 1'b0;
        end else begin
            if (accept) begin
                r_s2_valid <= 1'b1;
            end else if (s2_complete) begin
                r_s2_valid <= 1'b0;
            end
            if (build_step && build_res.err) begin
                r_halted <= 1'b1;
            end
            if (root_load) begin
                r_tree_ready <= 1'b1;
            end
            if (i_cfg_we) begin
                r_out_count <= i_cfg_wdata;
            end
            r_out_valid <= n_out_valid;
        end
    end

    // Capture item payload and the output register
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_s2_item <= i_in_item;
        end
        if (s2_complete && s2_has_res) begin
            r_out_item <= s2_res;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out_item;

    a_halt_sticky: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_halted |=> r_halted)
        else $error("halt flag cleared without reset");

    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && i_out_stall) |-> !(s2_complete && s2_has_res))
        else $error("held result overwritten");

    a_symbol_needs_tree: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out_item.status == htd_pkg::ST_SYMBOL) |-> r_tree_ready)
        else $error("symbol result before the tree is complete");

endmodule
